FILE: design/tlr_pkg.sv
// ============================================================================
// tlr_pkg
// Shared widths, constants, register indexes and types for the triplet loss
// row block.
// ============================================================================
package tlr_pkg;

    localparam int IDX_W      = 8;
    localparam int LABEL_W    = 16;
    localparam int DIST_W     = 16;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 9;
    localparam int NEG_W      = 16;
    localparam int LOSS_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 13;

    localparam int DIST_WIDTH_DEF = 16;

    localparam logic [NEG_W-1:0]      NEG_START     = NEG_W'(3 << FRAC_BITS);
    localparam logic [CFG_DATA_W-1:0] MARGIN_RESET  = CFG_DATA_W'(1638);
    localparam logic [CFG_DATA_W-1:0] HWEIGHT_RESET = CFG_DATA_W'(8192);

    localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HWEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage

FILE: design/tlr_if.sv
// ============================================================================
// tlr_if
// Handshake channels of the triplet loss row block: input items, results
// and register writes.
// ============================================================================
interface tlr_in_if;
    logic                           valid;
    logic                           ready;
    logic [tlr_pkg::IDX_W-1:0]      anchor_index;
    logic [tlr_pkg::IDX_W-1:0]      other_index;
    logic [tlr_pkg::LABEL_W-1:0]    anchor_label;
    logic [tlr_pkg::LABEL_W-1:0]    other_label;
    logic [tlr_pkg::DIST_W-1:0]     pair_distance;
    logic                           row_end;

    modport source (output valid, anchor_index, other_index, anchor_label, other_label,
                    pair_distance, row_end, input ready);
    modport sink   (input valid, anchor_index, other_index, anchor_label, other_label,
                    pair_distance, row_end, output ready);
endinterface

interface tlr_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlr_pkg::LOSS_W-1:0]     loss_value;
    logic [tlr_pkg::IDX_W-1:0]      loss_anchor;
    logic                           no_positive;
    logic                           saturated;

    modport source (output valid, loss_value, loss_anchor, no_positive, saturated,
                    input ready);
    modport sink   (input valid, loss_value, loss_anchor, no_positive, saturated,
                    output ready);
endinterface

interface tlr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tlr_pkg::CFG_IDX_W-1:0]  index;
    logic [tlr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tlr_div.sv
// ============================================================================
// tlr_div
// Restoring divider: one quotient bit per cycle, sum over positive count.
// ============================================================================
module tlr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlr_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [tlr_pkg::SUM_W-1:0]   o_quotient
);

    localparam int STEPS = tlr_pkg::SUM_W;
    localparam int STEP_W = $clog2(STEPS);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [tlr_pkg::SUM_W-1:0]   r_quo;
    logic [tlr_pkg::CNT_W-1:0]   r_rem;
    logic [tlr_pkg::CNT_W-1:0]   r_divisor;

    logic [tlr_pkg::CNT_W:0]     w_rem_s;
    logic                        w_ge;
    logic [tlr_pkg::CNT_W:0]     w_rem_sub;

    assign w_rem_s   = {r_rem, r_quo[tlr_pkg::SUM_W-1]};
    assign w_ge      = w_rem_s >= {1'b0, r_divisor};
    assign w_rem_sub = w_rem_s - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tlr_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[tlr_pkg::CNT_W-1:0] : w_rem_s[tlr_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/triplet_loss_row_forward.sv
// ============================================================================
// triplet_loss_row_forward
// Batch-hard triplet loss, forward pass, one distance-matrix row at a time.
// ============================================================================
// Usage:
//   i_in carries one distance element per beat in row-major order, with the
//   anchor/other indices and labels; row_end marks the row's last beat.
//   o_out carries one loss beat per row (loss, anchor, no_positive,
//   saturated). i_cfg writes margin_q (index 0) and hinge_weight (index 1);
//   it is always ready and should be used only while the block is idle.
// Timing:
//   A beat without row_end leaves ready high. A row_end beat with positives
//   holds ready low while the restoring divider works (one quotient bit
//   per cycle), then through the handoff, the hinge multiply and the
//   final add/clamp, which waits while a pending result is not taken.
//   Without positives, ready is low only for the final add/clamp step.
//   The result sits in an output register; further rows are accepted while
//   it waits, and a later row stalls at its final step until it is taken.
// Reset: synchronous, active low; clears accumulators (min to 3.0), the
//   registers to their defaults and any pending result.
// ============================================================================
module triplet_loss_row_forward #(
    parameter int DIST_WIDTH = tlr_pkg::DIST_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tlr_cfg_if.sink i_cfg,
    tlr_in_if.sink  i_in,
    tlr_out_if.source o_out
);

    localparam int DW_USED = (DIST_WIDTH < tlr_pkg::DIST_W) ? DIST_WIDTH : tlr_pkg::DIST_W;
    localparam logic [tlr_pkg::DIST_W-1:0] DIST_MASK =
        tlr_pkg::DIST_W'((33'd1 << DW_USED) - 33'd1);

    localparam int UP_W   = tlr_pkg::SUM_W + 1;
    localparam int PROD_W = tlr_pkg::CFG_DATA_W + UP_W;
    localparam int WGT_W  = PROD_W - tlr_pkg::FRAC_BITS;
    localparam int LSUM_W = WGT_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                      r_state;
    logic [tlr_pkg::CFG_DATA_W-1:0]  r_margin;
    logic [tlr_pkg::CFG_DATA_W-1:0]  r_hweight;
    logic [tlr_pkg::SUM_W-1:0]       r_pos_sum;
    logic [tlr_pkg::CNT_W-1:0]       r_pos_cnt;
    logic [tlr_pkg::NEG_W-1:0]       r_neg_min;
    logic [tlr_pkg::NEG_W-1:0]       r_neg_hold;
    logic [tlr_pkg::IDX_W-1:0]       r_anchor;
    logic                            r_nopos;
    logic [tlr_pkg::SUM_W-1:0]       r_mean;
    logic [WGT_W-1:0]                r_weighted;
    logic                            r_out_valid;
    logic [tlr_pkg::LOSS_W-1:0]      r_out_loss;
    logic [tlr_pkg::IDX_W-1:0]       r_out_anchor;
    logic                            r_out_nopos;
    logic                            r_out_sat;

    logic [tlr_pkg::SUM_W-1:0]       n_pos_sum;
    logic [tlr_pkg::CNT_W-1:0]       n_pos_cnt;
    logic [tlr_pkg::NEG_W-1:0]       n_neg_min;

    logic                            w_accept;
    logic                            w_row_done;
    logic [tlr_pkg::DIST_W-1:0]      w_dist;
    logic [tlr_pkg::SUM_W:0]         w_sum_ext;
    logic                            w_fin_go;
    logic [UP_W-1:0]                 w_up;
    logic [UP_W-1:0]                 w_hinge;
    logic [PROD_W-1:0]               w_prod;
    logic [LSUM_W-1:0]               w_loss;
    logic                            w_loss_sat;
    logic                            w_div_done;
    logic [tlr_pkg::SUM_W-1:0]       w_quotient;
    tlr_pkg::t_div_req               w_div_req;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_row_done  = w_accept && i_in.row_end;

    // row accumulation, including the row_end beat itself
    assign w_dist    = i_in.pair_distance & DIST_MASK;
    assign w_sum_ext = {1'b0, r_pos_sum} + (tlr_pkg::SUM_W + 1)'(w_dist);

    always_comb begin
        n_pos_sum = r_pos_sum;
        n_pos_cnt = r_pos_cnt;
        n_neg_min = r_neg_min;
        if (i_in.anchor_index != i_in.other_index) begin
            if (i_in.anchor_label == i_in.other_label) begin
                n_pos_sum = w_sum_ext[tlr_pkg::SUM_W] ? '1 : w_sum_ext[tlr_pkg::SUM_W-1:0];
                n_pos_cnt = (&r_pos_cnt) ? r_pos_cnt : r_pos_cnt + tlr_pkg::CNT_W'(1);
            end else if (w_dist < r_neg_min) begin
                n_neg_min = w_dist;
            end
        end
    end

    assign w_div_req.start    = w_row_done && (n_pos_cnt != '0);
    assign w_div_req.dividend = n_pos_sum;
    assign w_div_req.divisor  = n_pos_cnt;

    tlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // hinge and weighting on the quotient
    assign w_up    = UP_W'(w_quotient) + UP_W'(r_margin);
    assign w_hinge = (w_up > UP_W'(r_neg_hold)) ? (w_up - UP_W'(r_neg_hold)) : '0;
    assign w_prod  = PROD_W'(r_hweight) * PROD_W'(w_hinge);

    assign w_loss     = LSUM_W'(r_mean) + LSUM_W'(r_weighted);
    assign w_loss_sat = |w_loss[LSUM_W-1:tlr_pkg::LOSS_W];
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_margin    <= tlr_pkg::MARGIN_RESET;
            r_hweight   <= tlr_pkg::HWEIGHT_RESET;
            r_pos_sum   <= '0;
            r_pos_cnt   <= '0;
            r_neg_min   <= tlr_pkg::NEG_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == tlr_pkg::REG_MARGIN) begin
                    r_margin <= i_cfg.data;
                end else if (i_cfg.index == tlr_pkg::REG_HWEIGHT) begin
                    r_hweight <= i_cfg.data;
                end
            end

            if (w_row_done) begin
                r_pos_sum <= '0;
                r_pos_cnt <= '0;
                r_neg_min <= tlr_pkg::NEG_START;
            end else if (w_accept) begin
                r_pos_sum <= n_pos_sum;
                r_pos_cnt <= n_pos_cnt;
                r_neg_min <= n_neg_min;
            end

            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_row_done) begin
                        r_state <= (n_pos_cnt == '0) ? S_FIN : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_done) begin
            r_neg_hold <= n_neg_min;
            r_anchor   <= i_in.anchor_index;
            r_nopos    <= (n_pos_cnt == '0);
        end
        if (r_state == S_MUL) begin
            r_mean     <= w_quotient;
            r_weighted <= w_prod[PROD_W-1:tlr_pkg::FRAC_BITS];
        end
        if (w_fin_go) begin
            r_out_anchor <= r_anchor;
            r_out_nopos  <= r_nopos;
            r_out_sat    <= !r_nopos && w_loss_sat;
            if (r_nopos) begin
                r_out_loss <= '0;
            end else if (w_loss_sat) begin
                r_out_loss <= '1;
            end else begin
                r_out_loss <= w_loss[tlr_pkg::LOSS_W-1:0];
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.loss_value  = r_out_loss;
    assign o_out.loss_anchor = r_out_anchor;
    assign o_out.no_positive = r_out_nopos;
    assign o_out.saturated   = r_out_sat;

    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_done |=> (r_pos_sum == '0) && (r_pos_cnt == '0) &&
                       (r_neg_min == tlr_pkg::NEG_START))
        else $error("row accumulators not cleared after row end");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_nopos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nopos) |-> ((r_out_loss == '0) && !r_out_sat))
        else $error("no-positive result carries nonzero loss");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (&r_out_loss))
        else $error("saturated result not at maximum");

endmodule
